[rtl/stti_pkg.sv]
// ----------------------------------------------------------------------------
// stti_pkg
// Shared constants, types, character decoders and a power-of-ten table for the size text parser.
// ----------------------------------------------------------------------------
package stti_pkg;

    localparam int SIZE_W                  = 63;
    localparam int CHAR_W                  = 8;
    localparam int UNIT_W                  = 3;
    localparam int UNIT_SHIFT              = 10;
    localparam int UNIT_LOG_MAX            = 40;
    localparam int POW10_W                 = 20;
    localparam int MAX_FRACTION_DIGITS_DEF = 4;

    localparam logic [SIZE_W-1:0] VALUE_MAX = {SIZE_W{1'b1}};

    localparam logic [UNIT_W-1:0] UNIT_NONE = 3'd0;
    localparam logic [UNIT_W-1:0] UNIT_K    = 3'd1;
    localparam logic [UNIT_W-1:0] UNIT_M    = 3'd2;
    localparam logic [UNIT_W-1:0] UNIT_G    = 3'd3;
    localparam logic [UNIT_W-1:0] UNIT_T    = 3'd4;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_K_UP  = 8'h4B;
    localparam logic [CHAR_W-1:0] CH_K_LO  = 8'h6B;
    localparam logic [CHAR_W-1:0] CH_M_UP  = 8'h4D;
    localparam logic [CHAR_W-1:0] CH_M_LO  = 8'h6D;
    localparam logic [CHAR_W-1:0] CH_G_UP  = 8'h47;
    localparam logic [CHAR_W-1:0] CH_G_LO  = 8'h67;
    localparam logic [CHAR_W-1:0] CH_T_UP  = 8'h54;
    localparam logic [CHAR_W-1:0] CH_T_LO  = 8'h74;

    typedef struct packed {
        logic [UNIT_W-1:0] unit;
        logic              overflow;
    } parse_status_t;

    function automatic logic is_digit(input logic [CHAR_W-1:0] ch);
        return (ch >= CH_ZERO) && (ch <= CH_NINE);
    endfunction

    function automatic logic is_blank(input logic [CHAR_W-1:0] ch);
        return (ch == CH_SPACE) || (ch == CH_TAB);
    endfunction

    function automatic logic [UNIT_W-1:0] suffix_unit(input logic [CHAR_W-1:0] ch);
        logic [UNIT_W-1:0] u;
        unique case (ch) inside
            CH_K_UP, CH_K_LO: u = UNIT_K;
            CH_M_UP, CH_M_LO: u = UNIT_M;
            CH_G_UP, CH_G_LO: u = UNIT_G;
            CH_T_UP, CH_T_LO: u = UNIT_T;
            default:          u = UNIT_NONE;
        endcase
        return u;
    endfunction

    function automatic logic [POW10_W-1:0] pow10(input logic [2:0] n);
        logic [POW10_W-1:0] p;
        unique case (n)
            3'd0:    p = 20'd1;
            3'd1:    p = 20'd10;
            3'd2:    p = 20'd100;
            3'd3:    p = 20'd1000;
            3'd4:    p = 20'd10000;
            3'd5:    p = 20'd100000;
            3'd6:    p = 20'd1000000;
            default: p = 20'd1;
        endcase
        return p;
    endfunction

endpackage

[rtl/stti_parse.sv]
// ----------------------------------------------------------------------------
// stti_parse
// Character front end: skips, accumulates digits and decodes the unit suffix.
// ----------------------------------------------------------------------------
module stti_parse #(
    parameter int MAX_FRACTION_DIGITS = stti_pkg::MAX_FRACTION_DIGITS_DEF,
    localparam int FRAC_W = $clog2(10 ** MAX_FRACTION_DIGITS),
    localparam int CNT_W  = $clog2(MAX_FRACTION_DIGITS + 1)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          char_beat,
    input  logic                          clear,
    input  logic [stti_pkg::CHAR_W-1:0]   char_code,
    output logic [stti_pkg::SIZE_W-1:0]   whole,
    output logic [FRAC_W-1:0]             frac,
    output logic [CNT_W-1:0]              digits,
    output stti_pkg::parse_status_t       status
);
    import stti_pkg::*;

    typedef enum logic [4:0] {
        PH_SKIP  = 5'b00001,
        PH_WHOLE = 5'b00010,
        PH_FRAC  = 5'b00100,
        PH_BLANK = 5'b01000,
        PH_DONE  = 5'b10000
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [SIZE_W-1:0]   whole_reg, whole_next;
    logic [FRAC_W-1:0]   frac_reg, frac_next;
    logic [CNT_W-1:0]    digits_reg, digits_next;
    logic [UNIT_W-1:0]   unit_reg, unit_next;
    logic                ovf_reg, ovf_next;
    logic [3:0]          digit;
    logic [SIZE_W+3:0]   whole_x10;
    logic [FRAC_W+3:0]   frac_x10;
    logic                dig;
    logic                blank;
    logic                sep;

    assign digit = char_code[3:0];
    assign dig   = is_digit(char_code);
    assign blank = is_blank(char_code);
    assign sep   = (char_code == CH_DOT) || (char_code == CH_COMMA);

    assign whole_x10 = {whole_reg, 3'b000} + {2'b00, whole_reg, 1'b0}
                     + (SIZE_W + 4)'(digit);
    assign frac_x10  = {frac_reg, 3'b000} + {2'b00, frac_reg, 1'b0}
                     + (FRAC_W + 4)'(digit);

    always_comb begin
        phase_next  = phase_reg;
        whole_next  = whole_reg;
        frac_next   = frac_reg;
        digits_next = digits_reg;
        unit_next   = unit_reg;
        ovf_next    = ovf_reg;
        if (clear) begin
            phase_next  = PH_SKIP;
            whole_next  = '0;
            frac_next   = '0;
            digits_next = '0;
            unit_next   = UNIT_NONE;
            ovf_next    = 1'b0;
        end else if (char_beat) begin
            unique case (phase_reg)
                PH_SKIP: begin
                    if (dig) begin
                        whole_next = SIZE_W'(digit);
                        phase_next = PH_WHOLE;
                    end
                end
                PH_WHOLE: begin
                    if (dig) begin
                        if (whole_x10 > (SIZE_W + 4)'(VALUE_MAX)) begin
                            whole_next = VALUE_MAX;
                            ovf_next   = 1'b1;
                        end else begin
                            whole_next = whole_x10[SIZE_W-1:0];
                        end
                    end else if (sep) begin
                        phase_next = PH_FRAC;
                    end else if (blank) begin
                        phase_next = PH_BLANK;
                    end else begin
                        unit_next  = suffix_unit(char_code);
                        phase_next = PH_DONE;
                    end
                end
                PH_FRAC: begin
                    if (dig) begin
                        if (digits_reg < CNT_W'(MAX_FRACTION_DIGITS)) begin
                            frac_next   = frac_x10[FRAC_W-1:0];
                            digits_next = digits_reg + 1'b1;
                        end
                    end else if (blank) begin
                        phase_next = PH_BLANK;
                    end else begin
                        unit_next  = suffix_unit(char_code);
                        phase_next = PH_DONE;
                    end
                end
                PH_BLANK: begin
                    if (!blank) begin
                        unit_next  = suffix_unit(char_code);
                        phase_next = PH_DONE;
                    end
                end
                PH_DONE: begin
                end
                default: begin
                    phase_next = PH_SKIP;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_SKIP;
            whole_reg  <= '0;
            frac_reg   <= '0;
            digits_reg <= '0;
            unit_reg   <= UNIT_NONE;
            ovf_reg    <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            whole_reg  <= whole_next;
            frac_reg   <= frac_next;
            digits_reg <= digits_next;
            unit_reg   <= unit_next;
            ovf_reg    <= ovf_next;
        end
    end

    assign whole           = whole_reg;
    assign frac            = frac_reg;
    assign digits          = digits_reg;
    assign status.unit     = unit_reg;
    assign status.overflow = ovf_reg;

endmodule

[rtl/stti_scale.sv]
// ----------------------------------------------------------------------------
// stti_scale
// Unit scaling, fraction divide and final sum on one shared add/sub unit.
// ----------------------------------------------------------------------------
module stti_scale #(
    parameter int MAX_FRACTION_DIGITS = stti_pkg::MAX_FRACTION_DIGITS_DEF,
    localparam int FRAC_W = $clog2(10 ** MAX_FRACTION_DIGITS),
    localparam int CNT_W  = $clog2(MAX_FRACTION_DIGITS + 1)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic                          dec_mode,
    input  logic [stti_pkg::SIZE_W-1:0]   whole_in,
    input  logic [FRAC_W-1:0]             frac_in,
    input  logic [CNT_W-1:0]              digits_in,
    input  stti_pkg::parse_status_t       status_in,
    output logic                          idle,
    output logic                          res_valid,
    input  logic                          res_take,
    output logic [stti_pkg::SIZE_W-1:0]   res_value,
    output logic                          res_overflow
);
    import stti_pkg::*;

    localparam int PROD_W = FRAC_W + UNIT_LOG_MAX;
    localparam int DIV_W  = FRAC_W;
    localparam int BIT_W  = $clog2(PROD_W);
    localparam int AW     = SIZE_W + UNIT_SHIFT + 1;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_TRIPLE = 6'b000010,
        ST_MUL    = 6'b000100,
        ST_DIV    = 6'b001000,
        ST_SUM    = 6'b010000,
        ST_OUT    = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    logic [SIZE_W-1:0]   whole_reg, whole_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [SIZE_W+1:0]   tmp_reg, tmp_next;
    logic [DIV_W-1:0]    rem_reg, rem_next;
    logic [DIV_W-1:0]    divisor_reg, divisor_next;
    logic [UNIT_W-1:0]   cnt_reg, cnt_next;
    logic [BIT_W-1:0]    bit_reg, bit_next;
    logic                dec_reg, dec_next;
    logic                ovf_reg, ovf_next;
    logic                sel_frac_reg, sel_frac_next;
    logic [SIZE_W-1:0]   value_reg, value_next;
    logic                rovf_reg, rovf_next;

    logic [SIZE_W-1:0]   mul_x;
    logic [AW-1:0]       alu_a;
    logic [AW-1:0]       alu_b;
    logic                alu_sub;
    logic [AW-1:0]       alu_out;
    logic [DIV_W:0]      trial;
    logic                borrow;
    state_t              mul_entry;

    assign mul_x     = sel_frac_reg ? SIZE_W'(prod_reg) : whole_reg;
    assign trial     = {rem_reg, prod_reg[PROD_W-1]};
    assign mul_entry = dec_reg ? ST_TRIPLE : ST_MUL;

    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        unique case (state_reg)
            ST_TRIPLE: begin
                alu_a = AW'({mul_x, 1'b0});
                alu_b = AW'(mul_x);
            end
            ST_MUL: begin
                alu_a   = AW'({mul_x, {UNIT_SHIFT{1'b0}}});
                alu_b   = dec_reg ? AW'({tmp_reg, 3'b000}) : '0;
                alu_sub = 1'b1;
            end
            ST_DIV: begin
                alu_a   = AW'(trial);
                alu_b   = AW'(divisor_reg);
                alu_sub = 1'b1;
            end
            ST_SUM: begin
                alu_a = AW'(whole_reg);
                alu_b = AW'(prod_reg);
            end
            default: begin
            end
        endcase
    end

    assign alu_out = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
    assign borrow  = alu_out[AW-1];

    always_comb begin
        state_next    = state_reg;
        whole_next    = whole_reg;
        prod_next     = prod_reg;
        tmp_next      = tmp_reg;
        rem_next      = rem_reg;
        divisor_next  = divisor_reg;
        cnt_next      = cnt_reg;
        bit_next      = bit_reg;
        dec_next      = dec_reg;
        ovf_next      = ovf_reg;
        sel_frac_next = sel_frac_reg;
        value_next    = value_reg;
        rovf_next     = rovf_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    whole_next    = whole_in;
                    prod_next     = PROD_W'(frac_in);
                    divisor_next  = DIV_W'(pow10(3'(digits_in)));
                    rem_next      = '0;
                    cnt_next      = status_in.unit;
                    bit_next      = BIT_W'(PROD_W - 1);
                    dec_next      = dec_mode;
                    ovf_next      = status_in.overflow;
                    sel_frac_next = 1'b0;
                    if (status_in.unit == UNIT_NONE) begin
                        state_next = ST_DIV;
                    end else if (dec_mode) begin
                        state_next = ST_TRIPLE;
                    end else begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_TRIPLE: begin
                tmp_next   = alu_out[SIZE_W+1:0];
                state_next = ST_MUL;
            end
            ST_MUL: begin
                if (!sel_frac_reg) begin
                    if (alu_out > AW'(VALUE_MAX)) begin
                        value_next = VALUE_MAX;
                        rovf_next  = 1'b1;
                        state_next = ST_OUT;
                    end else begin
                        whole_next    = alu_out[SIZE_W-1:0];
                        sel_frac_next = 1'b1;
                        state_next    = mul_entry;
                    end
                end else begin
                    prod_next     = alu_out[PROD_W-1:0];
                    sel_frac_next = 1'b0;
                    cnt_next      = cnt_reg - 1'b1;
                    state_next    = (cnt_reg == UNIT_K) ? ST_DIV : mul_entry;
                end
            end
            ST_DIV: begin
                if (borrow) begin
                    rem_next = trial[DIV_W-1:0];
                end else begin
                    rem_next = alu_out[DIV_W-1:0];
                end
                prod_next = {prod_reg[PROD_W-2:0], ~borrow};
                bit_next  = bit_reg - 1'b1;
                if (bit_reg == '0) begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                if (alu_out[SIZE_W]) begin
                    value_next = VALUE_MAX;
                    rovf_next  = 1'b1;
                end else begin
                    value_next = alu_out[SIZE_W-1:0];
                    rovf_next  = ovf_reg;
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (res_take) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        whole_reg    <= whole_next;
        prod_reg     <= prod_next;
        tmp_reg      <= tmp_next;
        rem_reg      <= rem_next;
        divisor_reg  <= divisor_next;
        cnt_reg      <= cnt_next;
        bit_reg      <= bit_next;
        dec_reg      <= dec_next;
        ovf_reg      <= ovf_next;
        sel_frac_reg <= sel_frac_next;
        value_reg    <= value_next;
        rovf_reg     <= rovf_next;
    end

    assign idle         = (state_reg == ST_IDLE);
    assign res_valid    = (state_reg == ST_OUT);
    assign res_value    = value_reg;
    assign res_overflow = rovf_reg;

endmodule

[rtl/size_text_to_integer_top.sv]
// ----------------------------------------------------------------------------
// size_text_to_integer_top
// Parses a size string such as "1.5 KiB" one character per beat into an
// integer, scaled by a binary or decimal unit, saturating on overflow.
// ----------------------------------------------------------------------------
//  Port group   Dir   Beat contents
//  s_*          in    one character, or end of text
//  m_*          out   scaled size and overflow flag, one per end-of-text beat
//  cfg_*        in    unit base select (1: powers of 1000)
//
//  An end-of-text beat scales by the unit (one pass per suffix rank 0..4, a
//  triple step before each multiply in decimal mode), divides the fraction
//  bit-serially over fraction width + 40 bits (54 at four fraction digits)
//  and sums on the shared add/sub unit, then s_ready returns with m_* valid.
//  Reset is synchronous, no clearing pass.
//  A result held on m_* does not stop input beats; a second finished result
//  waits for it to be taken and holds s_ready low meanwhile.
// ----------------------------------------------------------------------------
module size_text_to_integer_top #(
    parameter int MAX_FRACTION_DIGITS = stti_pkg::MAX_FRACTION_DIGITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [stti_pkg::CHAR_W-1:0]   s_char_code,
    input  logic                          s_end_of_text,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [stti_pkg::SIZE_W-1:0]   m_size_value,
    output logic                          m_overflowed,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_wdata
);
    import stti_pkg::*;

    localparam int FRAC_W = $clog2(10 ** MAX_FRACTION_DIGITS);
    localparam int CNT_W  = $clog2(MAX_FRACTION_DIGITS + 1);

    logic                dec_reg;
    logic                m_valid_reg;
    logic [SIZE_W-1:0]   m_value_reg;
    logic                m_ovf_reg;
    logic                in_beat;
    logic                char_beat;
    logic                end_beat;
    logic                idle;
    logic                res_valid;
    logic                res_take;
    logic [SIZE_W-1:0]   res_value;
    logic                res_overflow;
    logic [SIZE_W-1:0]   whole;
    logic [FRAC_W-1:0]   frac;
    logic [CNT_W-1:0]    digits;
    parse_status_t       status;

    assign s_ready   = idle;
    assign cfg_ready = 1'b1;
    assign in_beat   = s_valid && s_ready;
    assign char_beat = in_beat && !s_end_of_text;
    assign end_beat  = in_beat && s_end_of_text;
    assign res_take  = res_valid && (!m_valid_reg || m_ready);

    stti_parse #(
        .MAX_FRACTION_DIGITS (MAX_FRACTION_DIGITS)
    ) u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .char_beat (char_beat),
        .clear     (end_beat),
        .char_code (s_char_code),
        .whole     (whole),
        .frac      (frac),
        .digits    (digits),
        .status    (status)
    );

    stti_scale #(
        .MAX_FRACTION_DIGITS (MAX_FRACTION_DIGITS)
    ) u_scale (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .start         (end_beat),
        .dec_mode      (dec_reg),
        .whole_in      (whole),
        .frac_in       (frac),
        .digits_in     (digits),
        .status_in     (status),
        .idle          (idle),
        .res_valid     (res_valid),
        .res_take      (res_take),
        .res_value     (res_value),
        .res_overflow  (res_overflow)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dec_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                dec_reg <= cfg_wdata;
            end
            if (res_take) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (res_take) begin
            m_value_reg <= res_value;
            m_ovf_reg   <= res_overflow;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_size_value = m_value_reg;
    assign m_overflowed = m_ovf_reg;

endmodule

[rtl/stti_checker.sv]
// ----------------------------------------------------------------------------
// stti_checker
// Port-level assertions for the size text parser, bound to the top level.
// ----------------------------------------------------------------------------
module stti_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic [stti_pkg::CHAR_W-1:0]   s_char_code,
    input logic                          s_end_of_text,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [stti_pkg::SIZE_W-1:0]   m_size_value,
    input logic                          m_overflowed,
    input logic                          cfg_valid,
    input logic                          cfg_ready,
    input logic                          cfg_wdata
);
    import stti_pkg::*;

    logic end_beat;

    assign end_beat = s_valid && s_ready && s_end_of_text;

    // a held result stays put
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_size_value) && $stable(m_overflowed))
        else $error("result changed while stalled");

    // overflow always reports the saturated value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_overflowed |-> m_size_value == VALUE_MAX)
        else $error("overflow without saturation");

    // end of text makes the block busy
    assert property (@(posedge aclk) disable iff (!aresetn)
        end_beat |=> !s_ready)
        else $error("ready right after end of text");

    // no result appears in the cycle after end of text
    assert property (@(posedge aclk) disable iff (!aresetn)
        end_beat |=> !$rose(m_valid))
        else $error("result too early");

endmodule

bind size_text_to_integer_top stti_checker u_stti_checker (.*);
